// File: hdl/tps_pkg.sv
// Package: widths, per-edge pipeline types and divider/multiplier helpers for the slicer.
`default_nettype none
package tps_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    // quotient bits of the edge fraction (0 .. 2^FRAC_BITS inclusive)
    localparam int QBITS      = FRAC_BITS + 1;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = (QBITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int PROD_W     = COORD_BITS + 1 + QBITS;
    // capture, setup, divider stages, multiply, add, combine
    localparam int NSTAGE     = DIV_STAGES + 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]          mag_t;
    typedef logic [COORD_BITS+1:0]        rem_t;
    typedef logic [FRAC_BITS:0]           frac_t;
    typedef logic [PROD_W-1:0]            prod_t;
    typedef logic [1:0]                   count_t;

    // edge in the divider stages
    typedef struct packed {
        logic   cut;
        coord_t x1;
        coord_t y1;
        mag_t   dxm;
        mag_t   dym;
        logic   dxneg;
        logic   dyneg;
        mag_t   dm;
        rem_t   r;
        frac_t  q;
    } edge_div_t;

    // edge after the multiply
    typedef struct packed {
        logic   cut;
        coord_t x1;
        coord_t y1;
        logic   dxneg;
        logic   dyneg;
        mag_t   offx;
        mag_t   offy;
    } edge_mul_t;

    // crossing point of one edge
    typedef struct packed {
        logic   cut;
        coord_t px;
        coord_t py;
    } edge_pt_t;

    function automatic mag_t abs_diff(input coord_t a, input coord_t b, output logic neg);
        logic [COORD_BITS:0] d;
        d   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        neg = d[COORD_BITS];
        return neg ? mag_t'(-d) : mag_t'(d);
    endfunction

    // restoring division steps; steps beyond the quotient width pass through
    function automatic edge_div_t div_steps(input edge_div_t e, input int unsigned first);
        edge_div_t o;
        logic      bit_q;
        o = e;
        for (int unsigned j = 0; j < DIV_STEPS; j++) begin
            if (first + j < QBITS) begin
                bit_q = (o.r >= rem_t'(o.dm));
                if (bit_q) begin
                    o.r = o.r - rem_t'(o.dm);
                end
                o.r = rem_t'({o.r, 1'b0});
                o.q = frac_t'({o.q, bit_q});
            end
        end
        return o;
    endfunction

    function automatic mag_t scale_off(input mag_t m, input frac_t t);
        prod_t p;
        p = prod_t'(m) * prod_t'(t);
        return mag_t'(p >> FRAC_BITS);
    endfunction

    function automatic coord_t apply_off(input coord_t c, input logic neg, input mag_t off);
        logic [COORD_BITS:0] ce;
        logic [COORD_BITS:0] s;
        ce = {c[COORD_BITS-1], c};
        s  = neg ? ce - off : ce + off;
        return coord_t'(s[COORD_BITS-1:0]);
    endfunction

endpackage
`default_nettype wire

// File: hdl/tps_if.sv
// Interfaces: triangle input channel and segment result channel.
`default_nettype none
interface tri_if;
    import tps_pkg::*;
    logic   valid;
    logic   ready;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface seg_if;
    import tps_pkg::*;
    logic   valid;
    logic   ready;
    count_t cut_count;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    modport source (output valid, cut_count, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, cut_count, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// File: hdl/triangle_plane_slice.sv
// Top level: nine-stage triangle / horizontal plane intersection pipeline.
// Stages: nine register stages (1 capture, 1 setup, 4 divider, 1 multiply, 1 add,
// 1 combine/output register), in that order from the accepting edge to the output.
// Throughput: one triangle per cycle unless stalled; each edge runs in its own parallel unit.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, async) clears all valid bits and plane_height to zero.
`default_nettype none
module triangle_plane_slice (
    input  wire                   clk,
    input  wire                   rst_n,
    tri_if.sink                   tri_in,
    seg_if.source                 seg_out,
    input  wire                   plane_wr_en,
    input  wire tps_pkg::coord_t  plane_wr_data
);
    import tps_pkg::*;

    logic [NSTAGE-1:0] vld_reg;
    logic              advance;

    coord_t    plane_height_reg;
    coord_t    vx_reg [3];
    coord_t    vy_reg [3];
    coord_t    vz_reg [3];
    edge_div_t div_reg  [DIV_STAGES+1][3];
    edge_div_t div_next [DIV_STAGES+1][3];
    edge_mul_t mul_reg  [3];
    edge_mul_t mul_next [3];
    edge_pt_t  pt_reg   [3];
    edge_pt_t  pt_next  [3];

    count_t cnt_next;
    coord_t sx_next, sy_next, ex_next, ey_next;
    count_t cnt_reg;
    coord_t sx_reg, sy_reg, ex_reg, ey_reg;

    // global pipeline enable
    assign advance      = !vld_reg[NSTAGE-1] || seg_out.ready;
    assign tri_in.ready = advance;

    // plane height register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_height_reg <= '0;
        end
        else if (plane_wr_en)
        begin
            plane_height_reg <= plane_wr_data;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], tri_in.valid};
        end
    end

    // edge setup, divider, multiply and add stages
    always_comb
    begin
        logic   zn1, zn2;
        logic   nneg, dneg;
        mag_t   nm;
        for (int e = 0; e < 3; e++) begin
            zn1 = (plane_height_reg <= vz_reg[e]);
            zn2 = (plane_height_reg <= vz_reg[(e + 1) % 3]);
            div_next[0][e].cut = (zn1 != zn2);
            div_next[0][e].x1  = vx_reg[e];
            div_next[0][e].y1  = vy_reg[e];
            div_next[0][e].dxm = abs_diff(vx_reg[(e + 1) % 3], vx_reg[e],
                                          div_next[0][e].dxneg);
            div_next[0][e].dym = abs_diff(vy_reg[(e + 1) % 3], vy_reg[e],
                                          div_next[0][e].dyneg);
            nm = abs_diff(plane_height_reg, vz_reg[e], nneg);
            div_next[0][e].dm  = abs_diff(vz_reg[(e + 1) % 3], vz_reg[e], dneg);
            div_next[0][e].r   = rem_t'(nm);
            div_next[0][e].q   = '0;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                div_next[s][e] = div_steps(div_reg[s-1][e], (s - 1) * DIV_STEPS);
            end
            mul_next[e].cut   = div_reg[DIV_STAGES][e].cut;
            mul_next[e].x1    = div_reg[DIV_STAGES][e].x1;
            mul_next[e].y1    = div_reg[DIV_STAGES][e].y1;
            mul_next[e].dxneg = div_reg[DIV_STAGES][e].dxneg;
            mul_next[e].dyneg = div_reg[DIV_STAGES][e].dyneg;
            mul_next[e].offx  = scale_off(div_reg[DIV_STAGES][e].dxm,
                                          div_reg[DIV_STAGES][e].q);
            mul_next[e].offy  = scale_off(div_reg[DIV_STAGES][e].dym,
                                          div_reg[DIV_STAGES][e].q);
            pt_next[e].cut = mul_reg[e].cut;
            pt_next[e].px  = apply_off(mul_reg[e].x1, mul_reg[e].dxneg, mul_reg[e].offx);
            pt_next[e].py  = apply_off(mul_reg[e].y1, mul_reg[e].dyneg, mul_reg[e].offy);
        end
    end

    // combine the per-edge crossing points into start/end points
    always_comb
    begin
        cnt_next = 2'd0;
        sx_next  = '0;
        sy_next  = '0;
        ex_next  = '0;
        ey_next  = '0;
        if (pt_reg[0].cut)
        begin
            sx_next  = pt_reg[0].px;
            sy_next  = pt_reg[0].py;
            cnt_next = 2'd1;
        end
        if (pt_reg[1].cut)
        begin
            if (cnt_next != 2'd0)
            begin
                ex_next  = pt_reg[1].px;
                ey_next  = pt_reg[1].py;
                cnt_next = 2'd2;
            end
            else
            begin
                sx_next  = pt_reg[1].px;
                sy_next  = pt_reg[1].py;
                cnt_next = 2'd1;
            end
        end
        // closing edge only counts when it lands off the start point
        if (pt_reg[2].cut)
        begin
            ex_next = pt_reg[2].px;
            ey_next = pt_reg[2].py;
            if (pt_reg[2].px != sx_next || pt_reg[2].py != sy_next)
            begin
                cnt_next = 2'd2;
            end
        end
        if (cnt_next != 2'd2)
        begin
            ex_next = '0;
            ey_next = '0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vx_reg[0] <= tri_in.ax;
            vy_reg[0] <= tri_in.ay;
            vz_reg[0] <= tri_in.az;
            vx_reg[1] <= tri_in.bx;
            vy_reg[1] <= tri_in.by_coord;
            vz_reg[1] <= tri_in.bz;
            vx_reg[2] <= tri_in.cx;
            vy_reg[2] <= tri_in.cy;
            vz_reg[2] <= tri_in.cz;
            div_reg   <= div_next;
            mul_reg   <= mul_next;
            pt_reg    <= pt_next;
            cnt_reg   <= cnt_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
        end
    end

    assign seg_out.valid     = vld_reg[NSTAGE-1];
    assign seg_out.cut_count = cnt_reg;
    assign seg_out.start_x   = sx_reg;
    assign seg_out.start_y   = sy_reg;
    assign seg_out.end_x     = ex_reg;
    assign seg_out.end_y     = ey_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid |-> seg_out.cut_count != 2'd3)
        else $error("cut_count out of range");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_out.valid && seg_out.cut_count != 2'd2) |->
        (seg_out.end_x == '0 && seg_out.end_y == '0))
        else $error("end point not zero with fewer than two cuts");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_out.valid && seg_out.cut_count == 2'd0) |->
        (seg_out.start_x == '0 && seg_out.start_y == '0))
        else $error("start point not zero with no cut");

endmodule
`default_nettype wire
